FILE: rtl/mqar_pkg.sv
package mqar_pkg;

    // mqtt control packet types (upper nibble of the fixed header)
    localparam logic [3:0] PKT_CONNECT   = 4'd1;
    localparam logic [3:0] PKT_CONNACK   = 4'd2;
    localparam logic [3:0] PKT_PUBLISH   = 4'd3;
    localparam logic [3:0] PKT_PUBACK    = 4'd4;
    localparam logic [3:0] PKT_PUBREC    = 4'd5;
    localparam logic [3:0] PKT_SUBSCRIBE = 4'd8;
    localparam logic [3:0] PKT_SUBACK    = 4'd9;

    localparam logic [7:0] GRANT_FAILURE    = 8'h80;
    localparam logic [7:0] QOS_GRANT_MAX    = 8'd2;
    localparam logic [7:0] ACK_REMAINING    = 8'd2;
    localparam logic [7:0] CONNACK_ACCEPTED = 8'h00;
    localparam logic [1:0] QOS_AT_LEAST     = 2'd1;
    localparam logic [1:0] QOS_EXACTLY      = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [1:0] HEAD_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_ID_HI,
        PH_ID_LO,
        PH_SLEN_HI,
        PH_SLEN_LO,
        PH_STRING,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        RK_CONNACK,
        RK_SUBACK,
        RK_PUBACK,
        RK_PUBREC
    } reply_kind_t;

    typedef struct packed {
        reply_kind_t kind;
        logic [15:0] packet_id;
    } reply_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_CODES
    } back_state_t;

    function automatic logic [7:0] header_byte(input reply_kind_t kind);
        logic [7:0] b;
        unique case (kind)
            RK_CONNACK: b = {PKT_CONNACK, 4'h0};
            RK_SUBACK:  b = {PKT_SUBACK, 4'h0};
            RK_PUBACK:  b = {PKT_PUBACK, 4'h0};
            RK_PUBREC:  b = {PKT_PUBREC, 4'h0};
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/mqar_front.sv
module mqar_front #(
    parameter int MAX_TOPICS = 16,
    parameter int CW = 5,
    parameter int AW = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                q_push,
    output mqar_pkg::reply_t    q_reply,
    output logic [CW-1:0]       q_count,
    input  logic                suback_done,
    output logic                gw_en,
    output logic [AW-1:0]       gw_addr,
    output logic [7:0]          gw_data
);

    localparam int PW = $clog2(mqar_pkg::QUEUE_DEPTH + 2);

    mqar_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       kind_reg, kind_next;
    logic [1:0]       qos_reg, qos_next;
    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic [15:0]      string_left_reg, string_left_next;
    logic [15:0]      packet_id_reg, packet_id_next;
    logic [CW-1:0]    topic_count_reg, topic_count_next;
    logic [PW-1:0]    pending_reg, pending_next;

    logic             accept;
    logic             topic_byte;
    logic             finish;
    logic             room;
    logic             suback_push;
    mqar_pkg::phase_t after_string;

    assign topic_byte = (phase_reg == mqar_pkg::PH_TAIL) && (kind_reg == mqar_pkg::PKT_SUBSCRIBE);
    // a topic code may not overwrite the store while an earlier suback still reads it
    assign rx_stall   = q_full || (topic_byte && (pending_reg != '0));
    assign accept     = rx_valid && !rx_stall;
    assign room       = topic_count_reg < CW'(MAX_TOPICS);

    assign after_string = ((kind_reg != mqar_pkg::PKT_SUBSCRIBE) && (qos_reg != 2'd0))
                        ? mqar_pkg::PH_ID_HI : mqar_pkg::PH_TAIL;

    always_comb
    begin
        finish = 1'b0;
        if (accept)
        begin
            if (phase_reg == mqar_pkg::PH_LENGTH)
            begin
                finish = (rx_byte == 8'd0);
            end
            else if (phase_reg != mqar_pkg::PH_HEADER)
            begin
                finish = (bytes_left_reg == 8'd1);
            end
        end
    end

    // parser next state
    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        qos_next         = qos_reg;
        bytes_left_next  = bytes_left_reg;
        string_left_next = string_left_reg;
        packet_id_next   = packet_id_reg;
        topic_count_next = topic_count_reg;
        if (accept)
        begin
            unique case (phase_reg)
                mqar_pkg::PH_HEADER:
                begin
                    kind_next        = rx_byte[7:4];
                    qos_next         = rx_byte[2:1];
                    packet_id_next   = '0;
                    string_left_next = '0;
                    topic_count_next = '0;
                    phase_next       = mqar_pkg::PH_LENGTH;
                end
                mqar_pkg::PH_LENGTH:
                begin
                    bytes_left_next = rx_byte;
                    if (kind_reg == mqar_pkg::PKT_SUBSCRIBE)
                    begin
                        phase_next = mqar_pkg::PH_ID_HI;
                    end
                    else if (kind_reg == mqar_pkg::PKT_PUBLISH)
                    begin
                        phase_next = mqar_pkg::PH_SLEN_HI;
                    end
                    else
                    begin
                        phase_next = mqar_pkg::PH_TAIL;
                    end
                end
                mqar_pkg::PH_ID_HI:
                begin
                    packet_id_next = {8'h00, rx_byte};
                    phase_next     = mqar_pkg::PH_ID_LO;
                end
                mqar_pkg::PH_ID_LO:
                begin
                    packet_id_next = {packet_id_reg[7:0], rx_byte};
                    phase_next     = (kind_reg == mqar_pkg::PKT_SUBSCRIBE)
                                   ? mqar_pkg::PH_SLEN_HI : mqar_pkg::PH_TAIL;
                end
                mqar_pkg::PH_SLEN_HI:
                begin
                    string_left_next = {rx_byte, 8'h00};
                    phase_next       = mqar_pkg::PH_SLEN_LO;
                end
                mqar_pkg::PH_SLEN_LO:
                begin
                    string_left_next = {string_left_reg[15:8], rx_byte};
                    phase_next       = ({string_left_reg[15:8], rx_byte} == 16'd0)
                                     ? after_string : mqar_pkg::PH_STRING;
                end
                mqar_pkg::PH_STRING:
                begin
                    string_left_next = string_left_reg - 16'd1;
                    if (string_left_reg == 16'd1)
                    begin
                        phase_next = after_string;
                    end
                end
                mqar_pkg::PH_TAIL:
                begin
                    if (kind_reg == mqar_pkg::PKT_SUBSCRIBE)
                    begin
                        if (room)
                        begin
                            topic_count_next = topic_count_reg + CW'(1);
                        end
                        phase_next = mqar_pkg::PH_SLEN_HI;
                    end
                end
            endcase
            if ((phase_reg != mqar_pkg::PH_HEADER) && (phase_reg != mqar_pkg::PH_LENGTH))
            begin
                bytes_left_next = bytes_left_reg - 8'd1;
            end
            if (finish)
            begin
                phase_next = mqar_pkg::PH_HEADER;
            end
        end
    end

    // request into the reply queue and topic code writes
    always_comb
    begin
        q_push            = 1'b0;
        q_reply.kind      = mqar_pkg::RK_CONNACK;
        q_reply.packet_id = packet_id_next;
        q_count           = topic_count_next;
        if (finish)
        begin
            if (kind_reg == mqar_pkg::PKT_CONNECT)
            begin
                q_push = 1'b1;
            end
            else if (kind_reg == mqar_pkg::PKT_SUBSCRIBE)
            begin
                q_push       = 1'b1;
                q_reply.kind = mqar_pkg::RK_SUBACK;
            end
            else if (kind_reg == mqar_pkg::PKT_PUBLISH)
            begin
                if (qos_reg == mqar_pkg::QOS_AT_LEAST)
                begin
                    q_push       = 1'b1;
                    q_reply.kind = mqar_pkg::RK_PUBACK;
                end
                else if (qos_reg == mqar_pkg::QOS_EXACTLY)
                begin
                    q_push       = 1'b1;
                    q_reply.kind = mqar_pkg::RK_PUBREC;
                end
            end
        end
        gw_en   = accept && topic_byte && room;
        gw_addr = topic_count_reg[AW-1:0];
        gw_data = (rx_byte <= mqar_pkg::QOS_GRANT_MAX) ? rx_byte : mqar_pkg::GRANT_FAILURE;
    end

    assign suback_push  = q_push && (q_reply.kind == mqar_pkg::RK_SUBACK);
    assign pending_next = pending_reg + PW'(suback_push) - PW'(suback_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= mqar_pkg::PH_HEADER;
            kind_reg        <= '0;
            qos_reg         <= '0;
            bytes_left_reg  <= '0;
            string_left_reg <= '0;
            packet_id_reg   <= '0;
            topic_count_reg <= '0;
            pending_reg     <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            qos_reg         <= qos_next;
            bytes_left_reg  <= bytes_left_next;
            string_left_reg <= string_left_next;
            packet_id_reg   <= packet_id_next;
            topic_count_reg <= topic_count_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

FILE: rtl/mqar_fifo.sv
module mqar_fifo #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;

    assign full     = (fill_reg == NW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        fill_next = fill_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/mqar_back.sv
module mqar_back #(
    parameter int MAX_TOPICS = 16,
    parameter int CW = 5,
    parameter int AW = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  mqar_pkg::reply_t    q_reply,
    input  logic [CW-1:0]       q_count,
    input  logic                gw_en,
    input  logic [AW-1:0]       gw_addr,
    input  logic [7:0]          gw_data,
    output logic                suback_done,
    output logic                tx_valid,
    input  logic                tx_stall,
    output logic [7:0]          tx_byte,
    output logic                frame_end
);

    mqar_pkg::back_state_t state_reg, state_next;
    logic [1:0]            hidx_reg, hidx_next;
    logic [CW-1:0]         code_idx_reg, code_idx_next;
    mqar_pkg::reply_t      frame_reg;
    logic [CW-1:0]         frame_count_reg;

    logic [7:0]            grant_mem [MAX_TOPICS];
    logic [7:0]            rd_data_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;

    logic                  load;
    logic                  emit;
    logic [7:0]            cur_byte;
    logic                  cur_last;

    // output register may take a new byte when empty or being drained
    assign load = !out_valid_reg || !tx_stall;

    // byte selection for the current frame position
    always_comb
    begin
        cur_byte = rd_data_reg;
        cur_last = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            mqar_pkg::BK_IDLE:
            begin
                emit = 1'b0;
            end
            mqar_pkg::BK_HEAD:
            begin
                emit = load;
                unique case (hidx_reg)
                    2'd0: cur_byte = mqar_pkg::header_byte(frame_reg.kind);
                    2'd1: cur_byte = (frame_reg.kind == mqar_pkg::RK_SUBACK)
                                   ? mqar_pkg::ACK_REMAINING + 8'(frame_count_reg)
                                   : mqar_pkg::ACK_REMAINING;
                    2'd2: cur_byte = (frame_reg.kind == mqar_pkg::RK_CONNACK)
                                   ? mqar_pkg::CONNACK_ACCEPTED : frame_reg.packet_id[15:8];
                    2'd3: cur_byte = (frame_reg.kind == mqar_pkg::RK_CONNACK)
                                   ? mqar_pkg::CONNACK_ACCEPTED : frame_reg.packet_id[7:0];
                endcase
                cur_last = (hidx_reg == mqar_pkg::HEAD_LAST)
                        && ((frame_reg.kind != mqar_pkg::RK_SUBACK) || (frame_count_reg == '0));
            end
            mqar_pkg::BK_CODES:
            begin
                emit     = load;
                cur_byte = rd_data_reg;
                cur_last = (code_idx_reg + CW'(1)) == frame_count_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // frame sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        hidx_next     = hidx_reg;
        code_idx_next = code_idx_reg;
        q_pop         = 1'b0;
        suback_done   = 1'b0;
        unique case (state_reg)
            mqar_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    state_next    = mqar_pkg::BK_HEAD;
                    hidx_next     = '0;
                    code_idx_next = '0;
                end
            end
            mqar_pkg::BK_HEAD:
            begin
                if (load)
                begin
                    if (hidx_reg == mqar_pkg::HEAD_LAST)
                    begin
                        if (cur_last)
                        begin
                            state_next  = mqar_pkg::BK_IDLE;
                            suback_done = (frame_reg.kind == mqar_pkg::RK_SUBACK);
                        end
                        else
                        begin
                            state_next = mqar_pkg::BK_CODES;
                        end
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 2'd1;
                    end
                end
            end
            mqar_pkg::BK_CODES:
            begin
                if (load)
                begin
                    if (cur_last)
                    begin
                        state_next  = mqar_pkg::BK_IDLE;
                        suback_done = 1'b1;
                    end
                    else
                    begin
                        code_idx_next = code_idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = mqar_pkg::BK_IDLE;
            end
        endcase
    end

    // grant code store, read one code ahead of its use
    always_ff @(posedge clk)
    begin
        if (gw_en)
        begin
            grant_mem[gw_addr] <= gw_data;
        end
        rd_data_reg <= grant_mem[code_idx_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            frame_reg       <= q_reply;
            frame_count_reg <= q_count;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mqar_pkg::BK_IDLE;
            hidx_reg      <= '0;
            code_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hidx_reg     <= hidx_next;
            code_idx_reg <= code_idx_next;
            if (load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    assign tx_valid  = out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign frame_end = out_last_reg;

endmodule

FILE: rtl/mqtt_packet_ack_responder.sv
// Parses a received MQTT byte stream (fixed header, one length byte, body) and sends
// reply frames: CONNACK for CONNECT, SUBACK with one grant code per topic for SUBSCRIBE,
// PUBACK or PUBREC for PUBLISH at QoS 1 or 2. The parser takes one byte per cycle; it
// stalls only when its two-entry reply queue is full, or on a topic QoS byte while an
// earlier SUBACK still waits or is still being sent, since both share the grant code
// store. Reply frames leave one byte per cycle while tx_stall is low, idling between
// frames during each reply queue pop. Up to MAX_TOPICS topics per SUBSCRIBE are answered,
// later ones are parsed and dropped. The grant code store needs no clearing after reset.
module mqtt_packet_ack_responder #(
    parameter int MAX_TOPICS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       frame_end
);

    localparam int CW = $clog2(MAX_TOPICS + 1);
    localparam int AW = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
    localparam int QW = $bits(mqar_pkg::reply_t) + CW;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    mqar_pkg::reply_t push_reply;
    logic [CW-1:0]    push_count;
    mqar_pkg::reply_t pop_reply;
    logic [CW-1:0]    pop_count;
    logic             suback_done;
    logic             gw_en;
    logic [AW-1:0]    gw_addr;
    logic [7:0]       gw_data;

    mqar_front #(
        .MAX_TOPICS (MAX_TOPICS),
        .CW         (CW),
        .AW         (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_reply     (push_reply),
        .q_count     (push_count),
        .suback_done (suback_done),
        .gw_en       (gw_en),
        .gw_addr     (gw_addr),
        .gw_data     (gw_data)
    );

    mqar_fifo #(
        .WIDTH (QW),
        .DEPTH (mqar_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_count, push_reply}),
        .pop       (q_pop),
        .pop_data  ({pop_count, pop_reply}),
        .full      (q_full),
        .empty     (q_empty)
    );

    mqar_back #(
        .MAX_TOPICS (MAX_TOPICS),
        .CW         (CW),
        .AW         (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_reply     (pop_reply),
        .q_count     (pop_count),
        .gw_en       (gw_en),
        .gw_addr     (gw_addr),
        .gw_data     (gw_data),
        .suback_done (suback_done),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .tx_byte     (tx_byte),
        .frame_end   (frame_end)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("reply request pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("reply request popped from an empty queue");

    a_pop_needs_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !(tx_valid && frame_end && $rose(tx_valid)))
        else $error("frame end shown right after a pop");
`endif

endmodule
